@@ sv/twcsw_pkg.sv @@
`default_nettype none
package twcsw_pkg;

	localparam int SCREEN_HEIGHT_DEF = 1024;
	localparam int SCREEN_WIDTH_DEF  = 1024;
	localparam int RAY_COUNT_DEF     = 1024;

	localparam int IDX_W  = 10;
	localparam int FIX_W  = 24;
	localparam int TILE_W = 12;
	localparam int TEX_W  = 11;
	localparam int CFG_W  = 12;
	localparam int POS_W  = 11;
	localparam int PIX_W  = 10;
	localparam int STEP_W = 28;
	localparam int DIVN_W = 36;
	localparam int DIVD_W = 24;

	localparam logic [STEP_W-1:0] STEP_MAX = 28'hFFF_FFFF;
	localparam logic [STEP_W-1:0] POS_MAX  = 28'h7FF_FFFF;
	localparam logic [STEP_W-1:0] POS_MIN  = 28'h800_0000;

	localparam logic REQ_LOAD    = 1'b0;
	localparam logic REQ_ADVANCE = 1'b1;
	localparam logic [2:0] TEX_DOOR = 3'd4;

	localparam logic [TILE_W-1:0] TILE_SIZE_RST = 12'd64;
	localparam logic [TEX_W-1:0]  TEX_DIM_RST   = 11'd64;

	typedef enum logic [1:0] {
		CFG_TILE_SIZE  = 2'd0,
		CFG_TEX_WIDTH  = 2'd1,
		CFG_TEX_HEIGHT = 2'd2
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_MUL,
		ST_MOD,
		ST_COL
	} back_state_t;

	typedef struct packed {
		logic             req_type;
		logic [IDX_W-1:0] ray_index;
		logic [FIX_W-1:0] wall_height;
		logic [FIX_W-1:0] hit_x;
		logic [FIX_W-1:0] hit_y;
		logic [1:0]       wall_side;
		logic             is_door;
	} req_t;

	typedef struct packed {
		logic valid;
		req_t req;
	} queue_head_t;

endpackage
`default_nettype wire

@@ sv/textured_wall_column_span_walker.sv @@
`default_nettype none
// Textured wall column span walker. A load beat (req_type 0) sets up one
// ray's wall span: screen columns from the ray index, top and bottom rows
// clamped to the screen, the texture (door or the face hit), the texel column
// and a 12.16 texture step. Setup runs through a shared serial divider and a
// shift-add multiplier; the next beat waits in a two-entry queue meanwhile.
// Each advance beat (req_type 1) then yields one pixel per cycle while the
// output is not stalled, walking down the rows of a column and on to the
// next column, with last on the final pixel. Advance beats while no span is
// active are consumed with no result. Configuration registers (tile size,
// texture width, texture height) are written through cfg_write / cfg_index /
// cfg_data only while the block is idle, a rule for the user that the block
// does not enforce; texture height is also used live for the texel row clamp.
module textured_wall_column_span_walker
	import twcsw_pkg::*;
#(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int RAY_COUNT     = RAY_COUNT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_write,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire logic             req_type,
	input  wire logic [IDX_W-1:0] ray_index,
	input  wire logic [FIX_W-1:0] wall_height,
	input  wire logic [FIX_W-1:0] hit_x,
	input  wire logic [FIX_W-1:0] hit_y,
	input  wire logic [1:0]       wall_side,
	input  wire logic             is_door,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output logic [PIX_W-1:0]      screen_x,
	output logic [PIX_W-1:0]      screen_y,
	output logic [2:0]            texture_id,
	output logic [PIX_W-1:0]      texel_column,
	output logic [PIX_W-1:0]      texel_row,
	output logic                  last
);

	logic [TILE_W-1:0] tile_size_q;
	logic [TEX_W-1:0]  tex_width_q, tex_height_q;

	// Configuration registers; an index outside the list is ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q  <= TILE_SIZE_RST;
			tex_width_q  <= TEX_DIM_RST;
			tex_height_q <= TEX_DIM_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				CFG_TILE_SIZE:  tile_size_q  <= cfg_data;
				CFG_TEX_WIDTH:  tex_width_q  <= cfg_data[TEX_W-1:0];
				CFG_TEX_HEIGHT: tex_height_q <= cfg_data[TEX_W-1:0];
				default: ;
			endcase
		end
	end

	req_t        push_req;
	logic        full, pop;
	queue_head_t head;

	assign push_req = '{req_type, ray_index, wall_height, hit_x, hit_y, wall_side, is_door};
	assign in_stall = full;

	// The front takes beats into the queue whenever it has room.
	twcsw_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (in_valid && !full),
		.push_req(push_req),
		.full    (full),
		.pop     (pop),
		.head    (head)
	);

	// The back sets up spans and walks pixels into the output register.
	twcsw_back #(
		.SCREEN_HEIGHT(SCREEN_HEIGHT),
		.SCREEN_WIDTH (SCREEN_WIDTH),
		.RAY_COUNT    (RAY_COUNT)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.pop           (pop),
		.tile_size     (tile_size_q),
		.texture_width (tex_width_q),
		.texture_height(tex_height_q),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.screen_x      (screen_x),
		.screen_y      (screen_y),
		.texture_id    (texture_id),
		.texel_column  (texel_column),
		.texel_row     (texel_row),
		.last          (last)
	);

endmodule
`default_nettype wire

@@ sv/twcsw_front.sv @@
`default_nettype none
module twcsw_front
	import twcsw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire req_t        push_req,
	output logic             full,
	input  wire logic        pop,
	output queue_head_t      head
);

	// Two-entry queue between the front and the sequencer.
	req_t       mem_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head.valid = (count_q != 2'd0);
	assign head.req   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule
`default_nettype wire

@@ sv/twcsw_div.sv @@
`default_nettype none
module twcsw_div
	import twcsw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVN_W-1:0] dividend,
	input  wire logic [DIVD_W-1:0] divisor,
	output logic                   done,
	output logic [DIVN_W-1:0]      quotient,
	output logic [DIVD_W-1:0]      remainder
);

	// Restoring divider, one quotient bit per cycle.
	logic [DIVD_W:0]   rem_q;
	logic [DIVN_W-1:0] quo_q;
	logic [DIVD_W-1:0] dsr_q;
	logic [5:0]        cnt_q;
	logic              busy_q, done_q;
	logic [DIVD_W+1:0] trial;
	logic [DIVD_W+1:0] shifted;

	assign shifted   = {rem_q, quo_q[DIVN_W-1]};
	assign trial     = shifted - {2'b00, dsr_q};
	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q[DIVD_W-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			if (!trial[DIVD_W+1]) begin
				rem_q <= trial[DIVD_W:0];
			end else begin
				rem_q <= shifted[DIVD_W:0];
			end
			quo_q <= {quo_q[DIVN_W-2:0], ~trial[DIVD_W+1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'(DIVN_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ sv/twcsw_back.sv @@
`default_nettype none
module twcsw_back
	import twcsw_pkg::*;
#(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int RAY_COUNT     = RAY_COUNT_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire queue_head_t       head,
	output logic                   pop,
	input  wire logic [TILE_W-1:0] tile_size,
	input  wire logic [TEX_W-1:0]  texture_width,
	input  wire logic [TEX_W-1:0]  texture_height,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [PIX_W-1:0]       screen_x,
	output logic [PIX_W-1:0]       screen_y,
	output logic [2:0]             texture_id,
	output logic [PIX_W-1:0]       texel_column,
	output logic [PIX_W-1:0]       texel_row,
	output logic                   last
);

	localparam int CPROD_W = IDX_W + 1 + $clog2(SCREEN_WIDTH + 1);
	localparam int HALF    = SCREEN_HEIGHT * 256;
	localparam int PROD_W  = 53;
	// The column quotient by the ray count is a multiply by the rounded-up
	// reciprocal; with this shift it is exact over the whole numerator range.
	localparam int RC_SHIFT = CPROD_W + $clog2(RAY_COUNT);
	localparam int RCP_W    = 2 * CPROD_W + 1;
	localparam longint unsigned RC_MUL =
		((64'd1 << RC_SHIFT) + 64'(RAY_COUNT) - 64'd1) / 64'(RAY_COUNT);

	back_state_t state_q, state_d;

	logic [FIX_W-1:0]  h_q, coord_q;
	logic [POS_W-1:0]  top_q, bottom_q, row_q, col_q, end_q;
	logic [STEP_W-1:0] step_q, start_q, pos_q;
	logic [2:0]        tex_q;
	logic [PIX_W-1:0]  tcol_q;
	logic              active_q;
	logic              sign_q;
	logic [PROD_W-1:0] acc_q, mcand_q;
	logic [STEP_W-1:0] mplier_q;
	logic [4:0]        mcnt_q;

	logic              div_start, div_done;
	logic [DIVN_W-1:0] div_n, div_q;
	logic [DIVD_W-1:0] div_d, div_r;

	twcsw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_n),
		.divisor  (div_d),
		.done     (div_done),
		.quotient (div_q),
		.remainder(div_r)
	);

	// Span setup from the queue head.
	logic [CPROD_W-1:0] c0_num, c1_num;
	logic [RCP_W-1:0]   c0_prod, c1_prod;
	logic [CPROD_W-1:0] c0_full, c1_full;
	logic [POS_W-1:0]   c0, c1, top_d, bottom_d;
	logic signed [25:0] v;
	logic [25:0]        bsum;
	logic [16:0]        bshift;

	always_comb begin
		c0_num  = CPROD_W'(head.req.ray_index) * CPROD_W'(SCREEN_WIDTH);
		c1_num  = (CPROD_W'(head.req.ray_index) + CPROD_W'(1)) * CPROD_W'(SCREEN_WIDTH);
		c0_prod = RCP_W'(c0_num) * RCP_W'(RC_MUL);
		c1_prod = RCP_W'(c1_num) * RCP_W'(RC_MUL);
		c0_full = CPROD_W'(c0_prod >> RC_SHIFT);
		c1_full = CPROD_W'(c1_prod >> RC_SHIFT);
		c0 = (c0_full > CPROD_W'(SCREEN_WIDTH)) ? POS_W'(SCREEN_WIDTH) : POS_W'(c0_full);
		c1 = (c1_full > CPROD_W'(SCREEN_WIDTH)) ? POS_W'(SCREEN_WIDTH) : POS_W'(c1_full);
		v = $signed(26'(HALF)) - $signed({2'b00, head.req.wall_height});
		top_d = (v <= 26'sd0) ? '0 : POS_W'(v >>> 9);
		bsum = 26'(HALF) + {2'b00, head.req.wall_height};
		bshift = 17'(bsum >> 9);
		bottom_d = (bshift > 17'(SCREEN_HEIGHT)) ? POS_W'(SCREEN_HEIGHT) : POS_W'(bshift);
	end

	// Offset of the clamped top from the true wall top.
	logic signed [26:0] off;
	logic [25:0]        off_mag;
	always_comb begin
		off = $signed({7'b0, top_q, 9'b0}) - $signed(27'(HALF)) + $signed({3'b0, h_q});
		off_mag = off[26] ? 26'(-off) : 26'(off);
	end

	// Start position from the finished product.
	logic [PROD_W:0]    rounded;
	logic [PROD_W-9:0]  mag_q9;
	logic [STEP_W-1:0]  start_d;
	always_comb begin
		rounded = sign_q ? ({1'b0, acc_q} + (PROD_W+1)'(511)) : {1'b0, acc_q};
		mag_q9  = rounded[PROD_W:9];
		if (!sign_q) begin
			start_d = (mag_q9 > (PROD_W-8)'(POS_MAX)) ? POS_MAX : STEP_W'(mag_q9);
		end else begin
			start_d = (mag_q9 > (PROD_W-8)'(POS_MIN)) ? POS_MIN : STEP_W'(-mag_q9);
		end
	end

	// Pixel walk.
	logic              out_free, adv, is_load;
	logic [POS_W:0]    row_inc, col_inc;
	logic              fin, wrap;
	logic [STEP_W+1:0] pos_sum;
	logic [STEP_W-1:0] pos_next;
	logic [TEX_W-1:0]  lim;
	logic [TEX_W-1:0]  raw_row;
	logic [PIX_W-1:0]  row_d;

	always_comb begin
		out_free = !out_valid || !out_stall;
		is_load  = head.req.req_type == REQ_LOAD;
		row_inc  = {1'b0, row_q} + 12'd1;
		col_inc  = {1'b0, col_q} + 12'd1;
		wrap     = row_inc >= {1'b0, bottom_q};
		fin      = (col_inc >= {1'b0, end_q}) && wrap;
		pos_sum  = {{2{pos_q[STEP_W-1]}}, pos_q} + {2'b00, step_q};
		pos_next = ($signed(pos_sum) > $signed({2'b00, POS_MAX})) ? POS_MAX
			: pos_sum[STEP_W-1:0];
		if (texture_height == '0) begin
			lim = '0;
		end else if (texture_height > TEX_W'(1024)) begin
			lim = TEX_W'(1023);
		end else begin
			lim = texture_height - TEX_W'(1);
		end
		raw_row = pos_q[26:16];
		if (pos_q[STEP_W-1]) begin
			row_d = '0;
		end else begin
			row_d = PIX_W'((raw_row > lim) ? lim : raw_row);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (head.valid && is_load) state_d = ST_STEP;
			ST_STEP: if (div_done) state_d = ST_MUL;
			ST_MUL:  if (mcnt_q == 5'd0) state_d = ST_MOD;
			ST_MOD:  if (div_done) state_d = ST_COL;
			ST_COL:  if (div_done) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Control outputs.
	logic [19:0] t_units;
	logic [30:0] scaled;
	always_comb begin
		t_units   = {tile_size, 8'b0};
		scaled    = 31'(div_r) * 31'(texture_width);
		pop       = 1'b0;
		adv       = 1'b0;
		div_start = 1'b0;
		div_n     = '0;
		div_d     = '0;
		case (state_q)
			ST_IDLE: begin
				if (head.valid) begin
					if (is_load) begin
						pop       = 1'b1;
						div_start = 1'b1;
						div_n     = {1'b0, texture_height, 24'b0};
						div_d     = head.req.wall_height;
					end else if (!active_q || out_free) begin
						pop = 1'b1;
						adv = active_q;
					end
				end
			end
			ST_MUL: begin
				div_start = (mcnt_q == 5'd0);
				div_n     = DIVN_W'(coord_q);
				div_d     = DIVD_W'(t_units);
			end
			ST_MOD: begin
				div_start = div_done;
				div_n     = DIVN_W'(scaled);
				div_d     = DIVD_W'(t_units);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop && is_load) begin
					h_q      <= head.req.wall_height;
					coord_q  <= head.req.wall_side[1] ? head.req.hit_y : head.req.hit_x;
					tex_q    <= head.req.is_door ? TEX_DOOR : {1'b0, head.req.wall_side};
					top_q    <= top_d;
					bottom_q <= bottom_d;
					col_q    <= c0;
					end_q    <= c1;
				end else if (adv) begin
					if (wrap) begin
						col_q <= col_inc[POS_W-1:0];
						row_q <= top_q;
						pos_q <= start_q;
					end else begin
						row_q <= row_inc[POS_W-1:0];
						pos_q <= pos_next;
					end
				end
			end
			ST_STEP: begin
				if (div_done) begin
					if (h_q == '0 || div_q > DIVN_W'(STEP_MAX)) begin
						step_q   <= STEP_MAX;
						mplier_q <= STEP_MAX;
					end else begin
						step_q   <= div_q[STEP_W-1:0];
						mplier_q <= div_q[STEP_W-1:0];
					end
					sign_q  <= off[26];
					mcand_q <= PROD_W'(off_mag);
					acc_q   <= '0;
				end
			end
			ST_MUL: begin
				if (mplier_q[0]) acc_q <= acc_q + mcand_q;
				mcand_q  <= {mcand_q[PROD_W-2:0], 1'b0};
				mplier_q <= {1'b0, mplier_q[STEP_W-1:1]};
			end
			ST_MOD: begin
				if (div_done) start_q <= start_d;
			end
			ST_COL: begin
				if (div_done) begin
					if (tile_size == '0) begin
						tcol_q <= '0;
					end else begin
						tcol_q <= (div_q > DIVN_W'(1023)) ? PIX_W'(1023) : div_q[PIX_W-1:0];
					end
					row_q <= top_q;
					pos_q <= start_q;
				end
			end
			default: ;
		endcase
		if (adv && out_free) begin
			screen_x     <= col_q[PIX_W-1:0];
			screen_y     <= row_q[PIX_W-1:0];
			texture_id   <= tex_q;
			texel_column <= tcol_q;
			texel_row    <= row_d;
			last         <= fin;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			active_q  <= 1'b0;
			mcnt_q    <= '0;
			out_valid <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_STEP) mcnt_q <= 5'(STEP_W - 1);
			else if (state_q == ST_MUL) mcnt_q <= mcnt_q - 5'd1;
			if (pop && is_load) active_q <= 1'b0;
			else if (adv && fin) active_q <= 1'b0;
			else if (state_q == ST_COL && div_done)
				active_q <= (top_q < bottom_q) && (col_q < end_q);
			if (adv) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
		end
	end

endmodule
`default_nettype wire

@@ sv/twcsw_checker.sv @@
`default_nettype none
module twcsw_checker
	import twcsw_pkg::*;
#(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF,
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire logic [PIX_W-1:0] screen_x,
	input wire logic [PIX_W-1:0] screen_y,
	input wire logic [2:0]       texture_id,
	input wire logic [PIX_W-1:0] texel_column,
	input wire logic [PIX_W-1:0] texel_row,
	input wire logic             last
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(screen_y)
			&& $stable(texture_id) && $stable(texel_column)
			&& $stable(texel_row) && $stable(last))
		else $error("result beat changed while stalled");

	a_screen: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (32'(screen_x) < SCREEN_WIDTH) && (32'(screen_y) < SCREEN_HEIGHT))
		else $error("pixel outside the screen");

	a_texture: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> texture_id <= TEX_DOOR)
		else $error("texture id out of range");

endmodule

bind textured_wall_column_span_walker twcsw_checker #(
	.SCREEN_HEIGHT(SCREEN_HEIGHT),
	.SCREEN_WIDTH (SCREEN_WIDTH)
) u_twcsw_checker (.*);
`default_nettype wire

@@ tb/tb_textured_wall_column_span_walker.sv @@
`timescale 1ns / 1ps
// Testbench for the textured wall column span walker.
//
// Load beats set up one ray's wall span and advance beats walk it, one pixel
// per accepted advance. A behavioral span model inside this module follows
// every accepted input beat, keeps its own copy of the span state and of the
// three configuration registers, and queues the pixel each advance beat should
// produce. Every accepted output beat is checked field by field against the
// oldest queued pixel.
//
// The run starts with a short directed table under the reset configuration,
// then goes through four configuration phases with random spans. The spans are
// mostly well formed (a load followed by roughly as many advances as the span
// has pixels), mixed with raw noise beats, loads that cut a span short and
// advances while no span is active.
module tb_textured_wall_column_span_walker;
	import twcsw_pkg::*;

	localparam int SH = SCREEN_HEIGHT_DEF;
	localparam int SW = SCREEN_WIDTH_DEF;
	localparam int RC = RAY_COUNT_DEF;
	// Generous room for the setup of a load to finish.
	localparam int SETTLE_CYCLES = 400;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 500;

	typedef struct packed {
		logic [PIX_W-1:0] sx;
		logic [PIX_W-1:0] sy;
		logic [2:0]       tex;
		logic [PIX_W-1:0] tcol;
		logic [PIX_W-1:0] trow;
		logic             fin;
	} pixel_t;

	// Kind of a directed row: checked by the model only, a typed pixel, or a
	// beat that must produce no pixel at all.
	typedef enum int {ROW_MODEL, ROW_PIXEL, ROW_NONE} row_kind_t;

	typedef struct {
		req_t      req;
		row_kind_t kind;
		pixel_t    pix;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic req_type = 1'b0;
	logic [IDX_W-1:0] ray_index = '0;
	logic [FIX_W-1:0] wall_height = '0;
	logic [FIX_W-1:0] hit_x = '0;
	logic [FIX_W-1:0] hit_y = '0;
	logic [1:0] wall_side = '0;
	logic is_door = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [PIX_W-1:0] screen_x, screen_y, texel_column, texel_row;
	logic [2:0] texture_id;
	logic last;

	textured_wall_column_span_walker DUT (
		.clk(clk), .arst_n(arst_n),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .ray_index(ray_index), .wall_height(wall_height),
		.hit_x(hit_x), .hit_y(hit_y), .wall_side(wall_side), .is_door(is_door),
		.out_valid(out_valid), .out_stall(out_stall),
		.screen_x(screen_x), .screen_y(screen_y), .texture_id(texture_id),
		.texel_column(texel_column), .texel_row(texel_row), .last(last)
	);

	always #2 clk = ~clk;

	// Span model state, mirroring the block's registers.
	logic [TILE_W-1:0] m_tile;
	logic [TEX_W-1:0] m_tex_w, m_tex_h;
	int unsigned m_top, m_bottom, m_row, m_col, m_end;
	longint m_step, m_start, m_pos;
	logic [2:0] m_tex;
	logic [PIX_W-1:0] m_tcol;
	bit m_active;

	pixel_t pixel_q[$];
	// Count of pixels ever queued and the most recent one.
	int pix_count = 0;
	pixel_t pix_tail;
	int fails = 0;
	int send_pct = 0;
	int recv_pct = 0;
	int hold_token = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int quiet_cycles = 0;

	function automatic longint clamp_position(longint v);
		if (v > longint'(POS_MAX)) return longint'(POS_MAX);
		if (v < -longint'(POS_MAX) - 1) return -longint'(POS_MAX) - 1;
		return v;
	endfunction

	function automatic void model_reset();
		m_tile = TILE_SIZE_RST;
		m_tex_w = TEX_DIM_RST;
		m_tex_h = TEX_DIM_RST;
		m_top = 0; m_bottom = 0; m_row = 0; m_col = 0; m_end = 0;
		m_step = 0; m_start = 0; m_pos = 0;
		m_tex = '0; m_tcol = '0; m_active = 0;
	endfunction

	function automatic void model_config(cfg_reg_t idx, logic [CFG_W-1:0] val);
		case (idx)
			CFG_TILE_SIZE: m_tile = val[TILE_W-1:0];
			CFG_TEX_WIDTH: m_tex_w = val[TEX_W-1:0];
			CFG_TEX_HEIGHT: m_tex_h = val[TEX_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic void model_load(req_t r);
		longint h, v, bot, off, c0, c1, t, coord, col;
		h = longint'(r.wall_height);
		c0 = longint'(r.ray_index) * SW / RC;
		c1 = (longint'(r.ray_index) + 1) * SW / RC;
		if (c0 > SW) c0 = SW;
		if (c1 > SW) c1 = SW;
		v = longint'(SH) * 256 - h;
		m_top = (v <= 0) ? 0 : int'(v >>> 9);
		bot = (longint'(SH) * 256 + h) >>> 9;
		if (bot > SH) bot = SH;
		m_bottom = int'(bot);
		if (h == 0) m_step = longint'(STEP_MAX);
		else begin
			m_step = (longint'(m_tex_h) << 24) / h;
			if (m_step > longint'(STEP_MAX)) m_step = longint'(STEP_MAX);
		end
		off = longint'(m_top) * 512 - longint'(SH) * 256 + h;
		if (off >= 0) m_start = (off * m_step) >>> 9;
		else m_start = -(((-off) * m_step + 511) >>> 9);
		m_start = clamp_position(m_start);
		m_tex = r.is_door ? TEX_DOOR : {1'b0, r.wall_side};
		if (m_tile == 0) m_tcol = '0;
		else begin
			t = longint'(m_tile) * 256;
			coord = (r.wall_side >= 2) ? longint'(r.hit_y) : longint'(r.hit_x);
			col = (coord % t) * longint'(m_tex_w) / t;
			m_tcol = (col > 1023) ? 10'd1023 : col[PIX_W-1:0];
		end
		m_col = int'(c0);
		m_end = int'(c1);
		m_row = m_top;
		m_pos = m_start;
		m_active = (m_top < m_bottom) && (c0 < c1);
	endfunction

	// Follows one accepted beat; a pixel is queued when one is due.
	function automatic void model_beat(req_t r);
		pixel_t p;
		longint lim, tr;
		bit fin;
		if (r.req_type == REQ_LOAD) begin
			model_load(r);
			return;
		end
		if (!m_active) return;
		fin = (m_col + 1 >= m_end) && (m_row + 1 >= m_bottom);
		lim = longint'(m_tex_h) - 1;
		if (lim < 0) lim = 0;
		if (lim > 1023) lim = 1023;
		tr = (m_pos < 0) ? 0 : (m_pos >>> 16);
		if (tr > lim) tr = lim;
		p.sx = m_col[PIX_W-1:0];
		p.sy = m_row[PIX_W-1:0];
		p.tex = m_tex;
		p.tcol = m_tcol;
		p.trow = tr[PIX_W-1:0];
		p.fin = fin;
		pixel_q.push_back(p);
		pix_count++;
		pix_tail = p;
		m_pos = clamp_position(m_pos + m_step);
		m_row++;
		if (m_row >= m_bottom) begin
			m_col++;
			m_row = m_top;
			m_pos = m_start;
		end
		if (fin) m_active = 0;
	endfunction

	// Input monitor: the beat is taken at the edge where valid is high and
	// stall is low, so the model steps right there.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			model_beat('{req_type, ray_index, wall_height, hit_x, hit_y, wall_side, is_door});
	end

	// Output checker against the oldest queued pixel.
	always @(posedge clk) begin
		pixel_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_q.size() == 0) begin
				$error("unexpected pixel beat x=%0d y=%0d", screen_x, screen_y);
				fails++;
			end else begin
				e = pixel_q.pop_front();
				if (screen_x !== e.sx) begin
					$error("screen_x exp %0d got %0d", e.sx, screen_x); fails++;
				end
				if (screen_y !== e.sy) begin
					$error("screen_y exp %0d got %0d", e.sy, screen_y); fails++;
				end
				if (texture_id !== e.tex) begin
					$error("texture_id exp %0d got %0d", e.tex, texture_id); fails++;
				end
				if (texel_column !== e.tcol) begin
					$error("texel_column exp %0d got %0d", e.tcol, texel_column); fails++;
				end
				if (texel_row !== e.trow) begin
					$error("texel_row exp %0d got %0d", e.trow, texel_row); fails++;
				end
				if (last !== e.fin) begin
					$error("last exp %0d got %0d", e.fin, last); fails++;
				end
			end
		end
	end

	// Receiver side. A long hold is requested by bumping hold_token; the
	// countdown itself lives here.
	always @(posedge clk) begin
		if (hold_token != hold_seen) begin
			hold_seen <= hold_token;
			hold_left <= LONG_HOLD;
			out_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < recv_pct);
		end
	end

	// Watchdog on cycles with no beat on either channel.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_textured_wall_column_span_walker NOT OK");
			$finish;
		end
	end

	// Offers one beat and returns at the edge where it is taken. A random gap
	// may come first; otherwise valid stays high from the previous beat.
	task automatic send_beat(req_t r);
		if ($urandom_range(0, 99) < send_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= r.req_type;
		ray_index <= r.ray_index;
		wall_height <= r.wall_height;
		hit_x <= r.hit_x;
		hit_y <= r.hit_y;
		wall_side <= r.wall_side;
		is_door <= r.is_door;
		forever begin
			@(posedge clk);
			if (!in_stall) break;
		end
		// The input monitor steps the model at this edge before the caller
		// looks at the model state.
		#0;
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		model_config(idx, val);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// Waits until every queued pixel has come, then lets a pending setup end.
	task automatic drain_pixels();
		in_valid <= 1'b0;
		while (pixel_q.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic req_t random_load();
		req_t r;
		int pick;
		r.req_type = REQ_LOAD;
		r.ray_index = $urandom();
		r.hit_x = $urandom();
		r.hit_y = $urandom();
		r.wall_side = $urandom();
		r.is_door = ($urandom_range(0, 5) == 0);
		pick = $urandom_range(0, 99);
		if (pick < 80) r.wall_height = $urandom_range(1, 256 * 24);
		else if (pick < 92) r.wall_height = $urandom();
		else if (pick < 96) r.wall_height = '0;
		else r.wall_height = '1;
		return r;
	endfunction

	function automatic req_t advance_beat();
		req_t r;
		r = random_load();
		r.req_type = REQ_ADVANCE;
		return r;
	endfunction

	// One random span: mostly a load walked to its end, sometimes cut short or
	// overrun, sometimes pure noise.
	task automatic random_span(inout int items);
		req_t r;
		int n, pixels;
		if ($urandom_range(0, 9) == 0) begin
			r = random_load();
			r.req_type = $urandom();
			send_beat(r);
			items++;
			return;
		end
		send_beat(random_load());
		items++;
		pixels = m_active ? int'((m_bottom - m_top) * (m_end - m_col)) : 0;
		n = pixels + $urandom_range(0, 2);
		if (n > 150 && $urandom_range(0, 3) != 0) n = $urandom_range(1, 150);
		if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
		repeat (n) begin
			send_beat(advance_beat());
			items++;
		end
	endtask

	dir_row_t dir_rows[$];

	task automatic add_row(logic rt, int idx, int h, int hx, int hy, int side, int door,
			row_kind_t kind, pixel_t pix);
		dir_row_t d;
		d.req = '{rt, idx[IDX_W-1:0], h[FIX_W-1:0], hx[FIX_W-1:0], hy[FIX_W-1:0],
			side[1:0], door[0]};
		d.kind = kind;
		d.pix = pix;
		dir_rows.push_back(d);
	endtask

	initial begin
		int items;
		int qs;
		pixel_t none;
		none = '0;
		pix_tail = '0;
		model_reset();

		// Under the reset configuration a two-row wall of height 2.0 at ray 0
		// sits on rows 511 and 512, starts its texture at row 0 and steps by
		// 32 texel rows. Its texel column is the hit x in map units mod 64.
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_NONE, none);
		add_row(REQ_LOAD, 0, 512, 'h1234, 0, 0, 0, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_PIXEL, '{10'd0, 10'd511, 3'd0, 10'd18, 10'd0, 1'b0});
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_PIXEL, '{10'd0, 10'd512, 3'd0, 10'd18, 10'd32, 1'b1});
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_NONE, none);
		// Tallest wall at the last ray on a door, west face.
		add_row(REQ_LOAD, 1023, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 3, 1, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		// A zero height wall replaces the active span and leaves nothing to draw.
		add_row(REQ_LOAD, 512, 0, 'h5A5A5A, 'hA5A5A5, 2, 0, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_NONE, none);
		// Smallest nonzero height gives a single pixel, east face.
		add_row(REQ_LOAD, 5, 1, 'hFFFFFF, 'hFFFFFF, 2, 0, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_NONE, none);
		// Exactly a full screen, south face, cut short by the next load.
		add_row(REQ_LOAD, 77, 'h40000, 'h00FF00, 0, 1, 0, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_LOAD, 300, 'h1FF, 'hFFFFFF, 'h0, 1, 0, ROW_NONE, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);
		add_row(REQ_ADVANCE, 0, 0, 0, 0, 0, 0, ROW_MODEL, none);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			qs = pix_count;
			send_beat(dir_rows[i].req);
			// Pixels leaving the queue meanwhile do not matter; only what this
			// beat added is looked at.
			if (dir_rows[i].kind == ROW_NONE && pix_count != qs) begin
				$error("row %0d: pixel queued where none is due", i); fails++;
			end
			if (dir_rows[i].kind == ROW_PIXEL &&
					(pix_count == qs || pix_tail !== dir_rows[i].pix)) begin
				$error("row %0d: pixel exp %h got %h", i, dir_rows[i].pix,
					(pix_count != qs) ? pix_tail : none);
				fails++;
			end
		end
		drain_pixels();

		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					write_reg(CFG_TILE_SIZE, 12'd64);
					write_reg(CFG_TEX_WIDTH, 12'd64);
					write_reg(CFG_TEX_HEIGHT, 12'd64);
					send_pct = 36; recv_pct = 55;
				end
				1: begin
					// Zero tile and zero texture height, widest texture.
					write_reg(CFG_TILE_SIZE, 12'd0);
					write_reg(CFG_TEX_WIDTH, 12'h7FF);
					write_reg(CFG_TEX_HEIGHT, 12'd0);
					send_pct = 55; recv_pct = 36;
				end
				2: begin
					write_reg(CFG_TILE_SIZE, 12'hFFF);
					write_reg(CFG_TEX_WIDTH, 12'd1);
					write_reg(CFG_TEX_HEIGHT, 12'h7FF);
					send_pct = 0; recv_pct = 0;
				end
				default: begin
					write_reg(CFG_TILE_SIZE, 12'($urandom_range(1, 4095)));
					write_reg(CFG_TEX_WIDTH, 12'($urandom_range(1, 1024)));
					write_reg(CFG_TEX_HEIGHT, 12'($urandom_range(1, 1024)));
				end
			endcase
			items = 0;
			if (phase == 0) begin
				// The receiver holds off while a full-screen span is offered,
				// so the block fills up and pushes back on its input.
				hold_token++;
				send_beat('{REQ_LOAD, 10'd9, 24'h40000, 24'h123456, 24'h654321,
					2'd0, 1'b0});
				repeat (40) send_beat(advance_beat());
				items += 41;
			end
			while (items < 375) random_span(items);
			drain_pixels();
		end

		if (fails == 0)
			$display("tb_textured_wall_column_span_walker OK");
		else
			$display("tb_textured_wall_column_span_walker NOT OK");
		$finish;
	end

endmodule
